// ===== hdl/bba_pkg.sv =====
package bba_pkg;

   // Store geometry
   localparam int BITMAP_BLOCKS   = 16;
   localparam int BLOCK_BYTES     = 512;
   localparam int WORD_BITS       = 64;
   localparam int BLOCK_BITS      = BLOCK_BYTES * 8;
   localparam int WORDS_PER_BLOCK = BLOCK_BITS / WORD_BITS;
   localparam int STORE_WORDS     = BITMAP_BLOCKS * WORDS_PER_BLOCK;

   localparam int BLOCK_AW    = $clog2(BITMAP_BLOCKS);
   localparam int WORD_IDX_W  = $clog2(WORDS_PER_BLOCK);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int BLOCK_BIT_W = $clog2(BLOCK_BITS);
   localparam int STORE_AW    = $clog2(STORE_WORDS);

   // Field widths
   localparam int OP_W     = 3;
   localparam int NUM_W    = 16;
   localparam int REGION_W = 2;
   localparam int SETV_W   = 2;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 13;
   localparam int CFG_W    = 5;
   localparam int CFG_IDX_W = 2;
   localparam int BLK_SUM_W = CFG_W + 1;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // Operation codes
   localparam logic [OP_W-1:0] OP_CLEAR_BLOCK = 3'd0;
   localparam logic [OP_W-1:0] OP_RAW_WRITE   = 3'd1;
   localparam logic [OP_W-1:0] OP_RAW_TEST    = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND_ZERO   = 3'd3;
   localparam logic [OP_W-1:0] OP_MAP_WRITE   = 3'd4;
   localparam logic [OP_W-1:0] OP_MAP_TEST    = 3'd5;

   // Region codes
   localparam logic [REGION_W-1:0] REGION_INODE = 2'd0;
   localparam logic [REGION_W-1:0] REGION_LOGIC = 2'd1;

   // Set values
   localparam logic [SETV_W-1:0] SET_CLEAR = 2'd0;
   localparam logic [SETV_W-1:0] SET_ONE   = 2'd1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_SET  = 2'd2;

   // Register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_INODE_BASE  = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_LOGIC_BASE  = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_LOGIC_LIMIT = 2'd2;

   localparam logic [CFG_W-1:0] INODE_BASE_RESET  = 5'd1;
   localparam logic [CFG_W-1:0] LOGIC_BASE_RESET  = 5'd2;
   localparam logic [CFG_W-1:0] LOGIC_LIMIT_RESET = 5'd16;

   typedef enum logic [2:0] {
      JOB_NONE  = 3'd0,
      JOB_CLEAR = 3'd1,
      JOB_TEST  = 3'd2,
      JOB_WRITE = 3'd3,
      JOB_FIND  = 3'd4
   } job_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic init_wr;
      logic clr_wr;
      logic rd_bit;
      logic wr_bit;
      logic take_bit;
      logic scan_start;
      logic scan;
      logic publish;
   } bba_cmd_type;

   // Datapath to controller
   typedef struct packed {
      job_type req_job;
      job_type job;
      logic    init_last;
      logic    cnt_last;
      logic    hit;
      logic    rsp_free;
   } bba_stat_type;

   // Lowest clear bit of a word, by halving the search window
   function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
      logic [WORD_BITS-1:0] z;
      logic [WORD_BITS-1:0] mask;
      logic [BIT_IDX_W-1:0] idx;
      z   = ~word;
      idx = '0;
      for (int k = BIT_IDX_W - 1; k >= 0; k--) begin
         mask = {WORD_BITS{1'b1}} >> (WORD_BITS - (1 << k));
         if ((z & mask) == '0) begin
            z      = z >> (1 << k);
            idx[k] = 1'b1;
         end
      end
      return idx;
   endfunction

endpackage

// ===== hdl/block_bitmap_allocator_unit.sv =====
// Block bitmap allocator: a store of 16 bitmap blocks of 4096 bits, held as
// 64-bit words in one single-port RAM, with one operation per item (clear a
// block, raw set/clear or test of a bit, find the lowest zero bit of a block,
// and mapped set/clear or test that adds the inode or logic region base and
// checks the region bound; other region codes map the number as is). Every
// item returns exactly one result item. Items are handled one at a time;
// the RAM port sets the pace. An item that is rejected at decode (overflow,
// bad set value, unused operation) goes straight to its result, a bit test
// or write reads the word, then tests it or writes it back, a block clear
// writes one word per cycle, and a find checks one word per cycle, stopping
// at the first word with a clear bit. After reset a clearing pass runs over
// the whole store, one word a cycle, before the first item is accepted;
// configuration writes are taken at any time. A finished result sits in an
// output register, so the next item is taken while it still waits on rsp_tready.
module block_bitmap_allocator_unit
   import bba_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [3:0] block_address, [19:4] bit_number, [21:20] region, [23:22] set_value
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // [2:0] operation
   input  logic [OP_W-1:0]        req_tuser,
   // Result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] status, [2] bit_value, [3] found, [16:4] first_zero_index, rest zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // Configuration write port
   input  logic                   csr_we,
   input  logic [CFG_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int REQ_NUM_LSB = BLOCK_AW;
   localparam int REQ_REG_LSB = REQ_NUM_LSB + NUM_W;
   localparam int REQ_SET_LSB = REQ_REG_LSB + REGION_W;
   localparam int RSP_USED_W  = STATUS_W + 2 + INDEX_W;

   bba_cmd_type  cmd;
   bba_stat_type stat;

   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_bit_value;
   logic                rsp_found;
   logic [INDEX_W-1:0]  rsp_first_zero_index;

   // Sequence the RAM work for each item
   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Decode, address generation, store and result register
   bba_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .operation            (req_tuser),
      .block_address        (req_tdata[BLOCK_AW-1:0]),
      .bit_number           (req_tdata[REQ_REG_LSB-1:REQ_NUM_LSB]),
      .region               (req_tdata[REQ_SET_LSB-1:REQ_REG_LSB]),
      .set_value            (req_tdata[REQ_SET_LSB+SETV_W-1:REQ_SET_LSB]),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_status           (rsp_status),
      .rsp_bit_value        (rsp_bit_value),
      .rsp_found            (rsp_found),
      .rsp_first_zero_index (rsp_first_zero_index)
   );

   // Pack the result, zero-fill to whole bytes
   assign rsp_tdata = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                       rsp_first_zero_index, rsp_found, rsp_bit_value, rsp_status};

   // One item at a time: an accept leaves the idle state at once
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while an item is in progress");

   // A bit write-back always follows the read of the same word
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_bit |-> $past(cmd.rd_bit))
      else $error("bit write-back without a preceding read");

   // No item is taken during the clearing pass
   a_init_block: assert property (@(posedge clock) disable iff (reset)
      cmd.init_wr |-> !req_tready)
      else $error("request ready during the clearing pass");

   // A result is loaded only when the output register is free
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrote a pending result");

endmodule

// ===== hdl/bba_ram.sv =====
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/bba_ctrl.sv =====
module bba_ctrl
   import bba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  bba_stat_type stat,
   output bba_cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_INIT       = 9'b000000001,
      S_IDLE       = 9'b000000010,
      S_CLEAR      = 9'b000000100,
      S_RD_BIT     = 9'b000001000,
      S_TEST       = 9'b000010000,
      S_MODIFY     = 9'b000100000,
      S_SCAN_START = 9'b001000000,
      S_SCAN       = 9'b010000000,
      S_DONE       = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.init_wr = 1'b1;
            if (stat.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               case (stat.req_job)
                  JOB_CLEAR: state_in = S_CLEAR;
                  JOB_TEST:  state_in = S_RD_BIT;
                  JOB_WRITE: state_in = S_RD_BIT;
                  JOB_FIND:  state_in = S_SCAN_START;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.cnt_last) begin
               state_in = S_DONE;
            end
         end
         S_RD_BIT: begin
            cmd.rd_bit = 1'b1;
            state_in   = (stat.job == JOB_TEST) ? S_TEST : S_MODIFY;
         end
         S_TEST: begin
            cmd.take_bit = 1'b1;
            state_in     = S_DONE;
         end
         S_MODIFY: begin
            cmd.wr_bit = 1'b1;
            state_in   = S_DONE;
         end
         S_SCAN_START: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit || stat.cnt_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/bba_dp.sv =====
module bba_dp
   import bba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  bba_cmd_type           cmd,
   output bba_stat_type          stat,
   input  logic [OP_W-1:0]       operation,
   input  logic [BLOCK_AW-1:0]   block_address,
   input  logic [NUM_W-1:0]      bit_number,
   input  logic [REGION_W-1:0]   region,
   input  logic [SETV_W-1:0]     set_value,
   input  logic                  csr_we,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_bit_value,
   output logic                  rsp_found,
   output logic [INDEX_W-1:0]    rsp_first_zero_index
);

   // Configuration
   logic [CFG_W-1:0] inode_base_ff, logic_base_ff, logic_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inode_base_ff  <= INODE_BASE_RESET;
         logic_base_ff  <= LOGIC_BASE_RESET;
         logic_limit_ff <= LOGIC_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CFG_INODE_BASE:  inode_base_ff  <= csr_wdata;
            CFG_LOGIC_BASE:  logic_base_ff  <= csr_wdata;
            CFG_LOGIC_LIMIT: logic_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Decode of the offered item
   logic [CFG_W-1:0]       base, bound;
   logic                   bound_en;
   logic [BLK_SUM_W-1:0]   map_sum;
   logic                   map_over, raw_blk_over, raw_bit_over, bad_set;
   job_type                dec_job;
   logic [STATUS_W-1:0]    dec_status;
   logic [BLOCK_AW-1:0]    dec_blk;

   always_comb begin
      base     = '0;
      bound    = '0;
      bound_en = 1'b0;
      case (region)
         REGION_INODE: begin
            base     = inode_base_ff;
            bound    = logic_base_ff;
            bound_en = 1'b1;
         end
         REGION_LOGIC: begin
            base     = logic_base_ff;
            bound    = logic_limit_ff;
            bound_en = 1'b1;
         end
         default: ;
      endcase
   end

   assign map_sum = BLK_SUM_W'(bit_number[NUM_W-1:BLOCK_BIT_W]) + BLK_SUM_W'(base);
   assign map_over = (bound_en && (map_sum >= BLK_SUM_W'(bound)))
                  || (map_sum >= BLK_SUM_W'(BITMAP_BLOCKS));
   assign raw_blk_over = ({1'b0, block_address} >= (BLOCK_AW + 1)'(BITMAP_BLOCKS));
   assign raw_bit_over = (bit_number >= NUM_W'(BLOCK_BITS));
   assign bad_set = !(set_value inside {SET_CLEAR, SET_ONE});

   always_comb begin
      dec_job    = JOB_NONE;
      dec_status = ST_OK;
      dec_blk    = block_address;
      case (operation)
         OP_CLEAR_BLOCK: begin
            if (raw_blk_over) dec_status = ST_OVERFLOW;
            else              dec_job    = JOB_CLEAR;
         end
         OP_RAW_WRITE: begin
            if (raw_blk_over || raw_bit_over) dec_status = ST_OVERFLOW;
            else if (bad_set)                 dec_status = ST_BAD_SET;
            else                              dec_job    = JOB_WRITE;
         end
         OP_RAW_TEST: begin
            if (raw_blk_over || raw_bit_over) dec_status = ST_OVERFLOW;
            else                              dec_job    = JOB_TEST;
         end
         OP_FIND_ZERO: begin
            if (raw_blk_over) dec_status = ST_OVERFLOW;
            else              dec_job    = JOB_FIND;
         end
         OP_MAP_WRITE: begin
            dec_blk = map_sum[BLOCK_AW-1:0];
            if (map_over)     dec_status = ST_OVERFLOW;
            else if (bad_set) dec_status = ST_BAD_SET;
            else              dec_job    = JOB_WRITE;
         end
         OP_MAP_TEST: begin
            dec_blk = map_sum[BLOCK_AW-1:0];
            if (map_over) dec_status = ST_OVERFLOW;
            else          dec_job    = JOB_TEST;
         end
         default: ;
      endcase
   end

   // Item registers
   job_type                 job_ff;
   logic [BLOCK_AW-1:0]     blk_ff;
   logic [BLOCK_BIT_W-1:0]  off_ff;
   logic                    set_ff;
   logic [WORD_IDX_W-1:0]   cnt_ff;
   logic [STORE_AW-1:0]     init_cnt_ff;
   logic [STATUS_W-1:0]     status_ff;
   logic                    bitv_ff, found_ff;
   logic [INDEX_W-1:0]      index_ff;

   // Store
   logic                    ram_we;
   logic [STORE_AW-1:0]     ram_addr;
   logic [WORD_BITS-1:0]    ram_wdata, ram_rdata, bit_mask;
   logic [WORD_IDX_W-1:0]   off_word;
   logic [BIT_IDX_W-1:0]    off_bit;

   assign off_word = off_ff[BLOCK_BIT_W-1:BIT_IDX_W];
   assign off_bit  = off_ff[BIT_IDX_W-1:0];
   assign bit_mask = WORD_BITS'(1) << off_bit;

   always_comb begin
      if (cmd.init_wr)                    ram_addr = init_cnt_ff;
      else if (cmd.rd_bit || cmd.wr_bit)  ram_addr = {blk_ff, off_word};
      else if (cmd.scan_start)            ram_addr = {blk_ff, {WORD_IDX_W{1'b0}}};
      else if (cmd.scan)                  ram_addr = {blk_ff, cnt_ff + WORD_IDX_W'(1)};
      else                                ram_addr = {blk_ff, cnt_ff};
   end

   assign ram_we    = cmd.init_wr || cmd.clr_wr || cmd.wr_bit;
   assign ram_wdata = !cmd.wr_bit ? '0
                    : (set_ff ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask));

   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   logic hit;
   assign hit = (~ram_rdata != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff <= '0;
      end else if (cmd.init_wr) begin
         init_cnt_ff <= init_cnt_ff + STORE_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff <= JOB_NONE;
      end else if (cmd.load) begin
         job_ff <= dec_job;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         blk_ff    <= dec_blk;
         off_ff    <= bit_number[BLOCK_BIT_W-1:0];
         set_ff    <= (set_value == SET_ONE);
         status_ff <= dec_status;
         bitv_ff   <= 1'b0;
         found_ff  <= 1'b0;
         index_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         if (cmd.clr_wr) begin
            cnt_ff <= cnt_ff + WORD_IDX_W'(1);
         end
         if (cmd.take_bit) begin
            bitv_ff <= ram_rdata[off_bit];
         end
         if (cmd.scan_start) begin
            cnt_ff <= '0;
         end
         if (cmd.scan) begin
            cnt_ff <= cnt_ff + WORD_IDX_W'(1);
            if (hit) begin
               found_ff <= 1'b1;
               index_ff <= INDEX_W'({cnt_ff, lowest_zero(ram_rdata)});
            end else begin
               index_ff <= INDEX_W'(BLOCK_BITS);
            end
         end
      end
   end

   // Result register
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_bitv_ff, rsp_found_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff <= status_ff;
         rsp_bitv_ff   <= bitv_ff;
         rsp_found_ff  <= found_ff;
         rsp_index_ff  <= index_ff;
      end
   end

   assign rsp_tvalid           = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_bit_value        = rsp_bitv_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_first_zero_index = rsp_index_ff;

   assign stat.req_job   = dec_job;
   assign stat.job       = job_ff;
   assign stat.init_last = (init_cnt_ff == STORE_AW'(STORE_WORDS - 1));
   assign stat.cnt_last  = (cnt_ff == WORD_IDX_W'(WORDS_PER_BLOCK - 1));
   assign stat.hit       = hit;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

endmodule

// ===== verif/block_bitmap_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module block_bitmap_allocator_unit_tb;
   import bba_pkg::*;

   // Codes with no name in the package: spare operations, absolute regions and
   // the two illegal set values
   localparam logic [OP_W-1:0]     OP_SPARE_6     = 3'd6;
   localparam logic [OP_W-1:0]     OP_SPARE_7     = 3'd7;
   localparam logic [REGION_W-1:0] REGION_ABS     = 2'd2;
   localparam logic [REGION_W-1:0] REGION_ABS_ALT = 2'd3;
   localparam logic [SETV_W-1:0]   SET_BAD_2      = 2'd2;
   localparam logic [SETV_W-1:0]   SET_BAD_3      = 2'd3;

   localparam logic [INDEX_W-1:0] NOT_FOUND_INDEX = INDEX_W'(BLOCK_BITS);

   // Bits filled at the front of one block so that find walks past whole words
   localparam int DEEP_FILL_BITS = 200;

   // Receiver stall patterns
   localparam logic [1:0] RX_OPEN = 2'd0;
   localparam logic [1:0] RX_COIN = 2'd1;
   localparam logic [1:0] RX_SLOW = 2'd2;
   localparam logic [1:0] RX_COMB = 2'd3;

   // Cycles with no handshake at all before the run is declared hung; covers
   // the clearing pass after reset plus the slowest item and longest stalls
   localparam int HANG_LIMIT = 8000;

   // One request item, as the block sees it across tuser and tdata
   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [SETV_W-1:0]   setv;
      logic [REGION_W-1:0] region;
      logic [NUM_W-1:0]    num;
      logic [BLOCK_AW-1:0] block;
   } alloc_req_type;

   // One result item, laid out exactly as rsp_tdata, lowest field last
   typedef struct packed {
      logic [RSP_DATA_W-INDEX_W-4-1:0] pad;
      logic [INDEX_W-1:0]              first_zero_index;
      logic                            found;
      logic                            bit_value;
      logic [STATUS_W-1:0]             status;
   } alloc_rsp_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CFG_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   // Shadow of the bitmap store and of the region registers
   logic [BLOCK_BITS-1:0] bitmap_shadow [BITMAP_BLOCKS];
   logic [CFG_W-1:0]      cfg_inode_base;
   logic [CFG_W-1:0]      cfg_logic_base;
   logic [CFG_W-1:0]      cfg_logic_limit;

   alloc_rsp_type outcomes_due [$];
   alloc_rsp_type last_outcome;
   alloc_rsp_type want_rsp;
   alloc_rsp_type got_rsp;

   int  error_count   = 0;
   int  results_seen  = 0;
   int  items_sent    = 0;
   int  tx_burst_left = 0;
   bit  tx_gaps_on    = 1'b1;
   int  hang_cycles   = 0;

   logic [1:0] rx_mode  = RX_OPEN;
   int         rx_count = 0;

   block_bitmap_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Write or test one bit at a block and bit that may be out of range
   function automatic alloc_rsp_type touch_bit(bit is_write, int blk, int pos,
                                               logic [SETV_W-1:0] setv);
      alloc_rsp_type r;
      r = '0;
      if (blk >= BITMAP_BLOCKS || pos >= BLOCK_BITS) begin
         r.status = ST_OVERFLOW;
      end else if (is_write) begin
         if (setv == SET_ONE) begin
            bitmap_shadow[blk][pos] = 1'b1;
         end else if (setv == SET_CLEAR) begin
            bitmap_shadow[blk][pos] = 1'b0;
         end else begin
            r.status = ST_BAD_SET;
         end
      end else begin
         r.bit_value = bitmap_shadow[blk][pos];
      end
      return r;
   endfunction

   // Apply one item to the shadow store and return the result it must give
   function automatic alloc_rsp_type bitmap_outcome(alloc_req_type it);
      alloc_rsp_type r;
      int            blk;
      int            pos;
      bit            over;
      r = '0;
      case (it.op)
         OP_CLEAR_BLOCK: begin
            bitmap_shadow[it.block] = '0;
         end
         OP_RAW_WRITE, OP_RAW_TEST: begin
            r = touch_bit(it.op == OP_RAW_WRITE, int'(it.block), int'(it.num), it.setv);
         end
         OP_FIND_ZERO: begin
            // Scan downward so the last hit is the lowest clear bit
            r.first_zero_index = NOT_FOUND_INDEX;
            for (int i = BLOCK_BITS - 1; i >= 0; i--) begin
               if (!bitmap_shadow[it.block][i]) begin
                  r.first_zero_index = i[INDEX_W-1:0];
                  r.found            = 1'b1;
               end
            end
         end
         OP_MAP_WRITE, OP_MAP_TEST: begin
            blk  = int'(it.num) / BLOCK_BITS;
            pos  = int'(it.num) % BLOCK_BITS;
            over = 1'b0;
            if (it.region == REGION_INODE) begin
               blk  = blk + int'(cfg_inode_base);
               over = blk >= int'(cfg_logic_base);
            end else if (it.region == REGION_LOGIC) begin
               blk  = blk + int'(cfg_logic_base);
               over = blk >= int'(cfg_logic_limit);
            end
            if (over) begin
               r.status = ST_OVERFLOW;
            end else begin
               r = touch_bit(it.op == OP_MAP_WRITE, blk, pos, it.setv);
            end
         end
         default: begin
            // spare operation codes: no effect, all result fields zero
         end
      endcase
      return r;
   endfunction

   function automatic alloc_req_type make_item(logic [OP_W-1:0] op, int blk, int num,
                                               logic [REGION_W-1:0] region,
                                               logic [SETV_W-1:0] setv);
      alloc_req_type it;
      it.op     = op;
      it.block  = blk[BLOCK_AW-1:0];
      it.num    = num[NUM_W-1:0];
      it.region = region;
      it.setv   = setv;
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Sender, drain and register writes
   // ------------------------------------------------------------------

   // Send one item: open a new burst after a random gap when the current one
   // is used up, hold the item until accepted, then predict its result. Valid
   // stays high on return so a following item goes out back to back.
   task automatic send_item(alloc_req_type it);
      int gap;
      if (tx_burst_left == 0) begin
         tx_burst_left = $urandom_range(1, 24);
         gap = tx_gaps_on ? $urandom_range(0, 10) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      tx_burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {it.setv, it.region, it.num, it.block};
      req_tuser  <= it.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      last_outcome = bitmap_outcome(it);
      outcomes_due.push_back(last_outcome);
      items_sent++;
   endtask

   // Drop valid and hold off until every predicted result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all three region registers back to back; call only when idle
   task automatic set_regions(logic [CFG_W-1:0] inode_base, logic [CFG_W-1:0] logic_base,
                              logic [CFG_W-1:0] logic_limit);
      csr_we    <= 1'b1;
      csr_index <= CFG_INODE_BASE;
      csr_wdata <= inode_base;
      @(posedge clock);
      csr_index <= CFG_LOGIC_BASE;
      csr_wdata <= logic_base;
      @(posedge clock);
      csr_index <= CFG_LOGIC_LIMIT;
      csr_wdata <= logic_limit;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_inode_base  = inode_base;
      cfg_logic_base  = logic_base;
      cfg_logic_limit = logic_limit;
   endtask

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   task automatic flag_mismatch(string what, int want, int got);
      $display("[%0t] mismatch on result %0d, %s: expected %0d, got %0d",
               $realtime, results_seen, what, want, got);
      error_count++;
   endtask

   // Compare each accepted result with the oldest prediction, field by field
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = alloc_rsp_type'(rsp_tdata);
         if (outcomes_due.size() == 0) begin
            flag_mismatch("result with nothing pending", 0, int'(rsp_tdata));
         end else begin
            want_rsp = outcomes_due.pop_front();
            if (got_rsp.status != want_rsp.status)
               flag_mismatch("status", want_rsp.status, got_rsp.status);
            if (got_rsp.bit_value != want_rsp.bit_value)
               flag_mismatch("bit_value", want_rsp.bit_value, got_rsp.bit_value);
            if (got_rsp.found != want_rsp.found)
               flag_mismatch("found", want_rsp.found, got_rsp.found);
            if (got_rsp.first_zero_index != want_rsp.first_zero_index)
               flag_mismatch("first_zero_index", want_rsp.first_zero_index,
                             got_rsp.first_zero_index);
            if (got_rsp.pad != '0)
               flag_mismatch("padding", 0, got_rsp.pad);
         end
         results_seen++;
      end
   end

   // Receiver: switch between stall patterns, each held for a random span
   always @(posedge clock) begin
      if (rx_count == 0) begin
         rx_mode  <= 2'($urandom_range(0, 3));
         rx_count <= $urandom_range(50, 300);
      end else begin
         rx_count <= rx_count - 1;
      end
      case (rx_mode)
         RX_OPEN: rsp_tready <= 1'b1;
         RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         RX_SLOW: rsp_tready <= ($urandom_range(0, 7) == 0);
         RX_COMB: rsp_tready <= rx_count[2] ^ rx_count[0];
         default: rsp_tready <= 1'b1;
      endcase
   end

   // Watchdog: end the run when no item moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         hang_cycles <= 0;
      end else begin
         hang_cycles <= hang_cycles + 1;
      end
      if (hang_cycles >= HANG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Raw bit access, find, clear and the spare codes at the reset settings
   task automatic test_raw_ops();
      send_item(make_item(OP_RAW_WRITE, 0, 0, REGION_INODE, SET_ONE));
      send_item(make_item(OP_RAW_WRITE, 15, BLOCK_BITS - 1, REGION_ABS_ALT, SET_ONE));
      // top bit of a byte must read back as plain 1
      send_item(make_item(OP_RAW_WRITE, 3, 7, REGION_LOGIC, SET_ONE));
      send_item(make_item(OP_RAW_TEST, 3, 7, REGION_INODE, SET_CLEAR));
      // tests ignore the set value, even an illegal one
      send_item(make_item(OP_RAW_TEST, 0, 0, REGION_ABS, SET_BAD_3));
      send_item(make_item(OP_RAW_TEST, 15, BLOCK_BITS - 1, REGION_INODE, SET_ONE));
      // bit number past the block
      send_item(make_item(OP_RAW_WRITE, 2, BLOCK_BITS, REGION_INODE, SET_ONE));
      send_item(make_item(OP_RAW_TEST, 2, 16'hFFFF, REGION_ABS_ALT, SET_BAD_3));
      send_item(make_item(OP_RAW_WRITE, 1, 5, REGION_INODE, SET_BAD_2));
      // overflow is checked before the set value
      send_item(make_item(OP_RAW_WRITE, 1, BLOCK_BITS, REGION_INODE, SET_BAD_3));
      send_item(make_item(OP_FIND_ZERO, 0, 0, REGION_INODE, SET_CLEAR));
      send_item(make_item(OP_FIND_ZERO, 5, 16'hFFFF, REGION_ABS_ALT, SET_BAD_3));
      send_item(make_item(OP_RAW_WRITE, 0, 0, REGION_INODE, SET_CLEAR));
      send_item(make_item(OP_SPARE_6, 15, 16'hFFFF, REGION_ABS_ALT, SET_BAD_3));
      send_item(make_item(OP_SPARE_7, 0, 0, REGION_INODE, SET_ONE));
      send_item(make_item(OP_CLEAR_BLOCK, 15, 16'hFFFF, REGION_ABS_ALT, SET_BAD_3));
      send_item(make_item(OP_RAW_TEST, 15, BLOCK_BITS - 1, REGION_INODE, SET_CLEAR));
      wait_drained();
   endtask

   // Mapped access through both regions and absolute numbering
   task automatic test_mapped_ops();
      send_item(make_item(OP_MAP_WRITE, 0, 0, REGION_INODE, SET_ONE));
      send_item(make_item(OP_RAW_TEST, 1, 0, REGION_INODE, SET_CLEAR));
      // inode region ends where the logic region starts
      send_item(make_item(OP_MAP_WRITE, 0, BLOCK_BITS, REGION_INODE, SET_ONE));
      send_item(make_item(OP_MAP_TEST, 7, 13 * BLOCK_BITS + 4095, REGION_LOGIC, SET_CLEAR));
      send_item(make_item(OP_MAP_WRITE, 0, 14 * BLOCK_BITS, REGION_LOGIC, SET_ONE));
      send_item(make_item(OP_MAP_TEST, 0, 16'hFFFF, REGION_ABS, SET_CLEAR));
      // region code three behaves as absolute
      send_item(make_item(OP_MAP_WRITE, 9, 3 * BLOCK_BITS + 7, REGION_ABS_ALT, SET_ONE));
      send_item(make_item(OP_MAP_WRITE, 0, 0, REGION_LOGIC, SET_BAD_2));
      wait_drained();
   endtask

   // Region registers at their extremes, including a base past the store
   task automatic test_region_settings();
      set_regions(5'd0, 5'd16, 5'd31);
      send_item(make_item(OP_MAP_WRITE, 0, 15 * BLOCK_BITS + 1, REGION_INODE, SET_ONE));
      send_item(make_item(OP_MAP_TEST, 0, 15 * BLOCK_BITS + 1, REGION_ABS, SET_CLEAR));
      // logic base 16 lands outside the store while under the limit
      send_item(make_item(OP_MAP_TEST, 0, 0, REGION_LOGIC, SET_CLEAR));
      wait_drained();
      set_regions(5'd16, 5'd0, 5'd0);
      send_item(make_item(OP_MAP_WRITE, 0, 0, REGION_INODE, SET_ONE));
      send_item(make_item(OP_MAP_TEST, 0, 0, REGION_LOGIC, SET_CLEAR));
      send_item(make_item(OP_MAP_TEST, 0, 15 * BLOCK_BITS + 1, REGION_ABS_ALT, SET_CLEAR));
      wait_drained();
      set_regions(INODE_BASE_RESET, LOGIC_BASE_RESET, LOGIC_LIMIT_RESET);
   endtask

   // Fill the front of one block bit by bit: find must walk past the full
   // words to the first clear bit, then move on once that bit is set
   task automatic test_deep_find();
      for (int i = 0; i < DEEP_FILL_BITS; i++)
         send_item(make_item(OP_RAW_WRITE, 6, i, 2'($urandom_range(0, 3)), SET_ONE));
      send_item(make_item(OP_FIND_ZERO, 6, 0, REGION_INODE, SET_CLEAR));
      send_item(make_item(OP_RAW_WRITE, 6, DEEP_FILL_BITS, REGION_INODE, SET_ONE));
      send_item(make_item(OP_FIND_ZERO, 6, 0, REGION_INODE, SET_CLEAR));
      send_item(make_item(OP_MAP_TEST, 0, 6 * BLOCK_BITS + DEEP_FILL_BITS, REGION_ABS,
                          SET_CLEAR));
      send_item(make_item(OP_CLEAR_BLOCK, 6, 0, REGION_INODE, SET_CLEAR));
      send_item(make_item(OP_FIND_ZERO, 6, 0, REGION_INODE, SET_CLEAR));
      wait_drained();
   endtask

   // Random traffic in phases with different region settings. Close to half
   // of it is allocate (find, then set the bit found) and free, so blocks fill
   // up and find reaches deep; the rest is mapped access, raw access and noise.
   task automatic test_random_traffic();
      int                  phase_end;
      int                  pick;
      int                  blk;
      int                  num;
      int                  hi;
      logic [REGION_W-1:0] region;
      logic [SETV_W-1:0]   setv;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_regions(INODE_BASE_RESET, LOGIC_BASE_RESET, LOGIC_LIMIT_RESET);
            1: set_regions(5'd0, 5'd0, 5'd0);
            2: set_regions(5'd16, 5'd16, 5'd16);
            3: set_regions(5'd0, 5'd8, 5'd16);
            default: set_regions(5'($urandom_range(0, 16)), 5'($urandom_range(0, 16)),
                                 5'($urandom_range(0, 16)));
         endcase
         // one phase runs without sender gaps
         tx_gaps_on = (phase != 2);
         phase_end  = items_sent + 150;
         while (items_sent < phase_end) begin
            pick   = $urandom_range(0, 99);
            region = 2'($urandom_range(0, 3));
            setv   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                 : 2'($urandom_range(0, 1));
            if (pick < 30) begin
               blk = $urandom_range(0, 3);
               send_item(make_item(OP_FIND_ZERO, blk, $urandom_range(0, 65535), region, setv));
               if (last_outcome.found)
                  send_item(make_item(OP_RAW_WRITE, blk, last_outcome.first_zero_index,
                                      region, SET_ONE));
            end else if (pick < 45) begin
               send_item(make_item(OP_RAW_WRITE, $urandom_range(0, 3), $urandom_range(0, 255),
                                   region, SET_CLEAR));
            end else if (pick < 70) begin
               hi  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
               num = hi * BLOCK_BITS + (($urandom_range(0, 1) == 1) ? $urandom_range(0, 255)
                                                                    : $urandom_range(0, 4095));
               send_item(make_item(($urandom_range(0, 1) == 1) ? OP_MAP_WRITE : OP_MAP_TEST,
                                   0, num, region, setv));
               send_item(make_item(OP_FIND_ZERO, $urandom_range(0, 15), 0, region, setv));
            end else if (pick < 90) begin
               num = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 4095);
               send_item(make_item(($urandom_range(0, 1) == 1) ? OP_RAW_WRITE : OP_RAW_TEST,
                                   $urandom_range(0, 15), num, region, setv));
            end else if (pick < 95) begin
               send_item(make_item(OP_CLEAR_BLOCK, $urandom_range(0, 15),
                                   $urandom_range(0, 65535), region, setv));
            end else begin
               // noise: any code, any fields
               send_item(make_item(3'($urandom_range(0, 7)), $urandom_range(0, 15),
                                   $urandom_range(0, 65535), region, 2'($urandom_range(0, 3))));
            end
            // halfway through, hold off until the block has caught up
            if (items_sent == phase_end - 75)
               wait_drained();
         end
         wait_drained();
      end
      tx_gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      for (int b = 0; b < BITMAP_BLOCKS; b++)
         bitmap_shadow[b] = '0;
      cfg_inode_base  = INODE_BASE_RESET;
      cfg_logic_base  = LOGIC_BASE_RESET;
      cfg_logic_limit = LOGIC_LIMIT_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_raw_ops();
      test_mapped_ops();
      test_region_settings();
      test_deep_find();
      test_random_traffic();

      // allow for the slowest item before the final verdict
      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
